>>> src/slip_xor_frame_encoder_macros.svh
// Assertion macros shared by the encoder checkers.
`ifndef SLIP_XOR_FRAME_ENCODER_MACROS_SVH
`define SLIP_XOR_FRAME_ENCODER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define SXFE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sxfe check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define SXFE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sxfe check failed");

`endif

>>> src/sxfe_pkg.sv
// Shared constants and types of the SLIP frame encoder with XOR checksum.
package sxfe_pkg;

  localparam logic [7:0] FRAME_END = 8'hC0;
  localparam logic [7:0] FRAME_ESC = 8'hDB;
  localparam logic [7:0] ESC_END   = 8'hDC;
  localparam logic [7:0] ESC_ESC   = 8'hDD;

  // Opening delimiter, two escaped bytes, two escaped checksum bytes, close.
  localparam int MAX_LINE = 6;
  localparam int CNT_W    = $clog2(MAX_LINE + 1);

  typedef logic [7:0] byte_t;

  // Line bytes produced by one input item, drained in order.
  typedef struct packed {
    logic [MAX_LINE-1:0][7:0] bytes;
    logic [CNT_W-1:0]         count;  // 1..MAX_LINE
    logic                     eof;    // final entry closes the frame
  } line_list_t;

  typedef struct packed {
    logic can_load;  // list register empties this cycle or is empty
  } ser_status_t;

  // Number of line bytes for one escaped byte.
  function automatic logic [CNT_W-1:0] esc_len(input byte_t b);
    esc_len = ((b == FRAME_END) || (b == FRAME_ESC)) ? CNT_W'(2) : CNT_W'(1);
  endfunction

  function automatic byte_t esc_first(input byte_t b);
    esc_first = ((b == FRAME_END) || (b == FRAME_ESC)) ? FRAME_ESC : b;
  endfunction

  function automatic byte_t esc_second(input byte_t b);
    esc_second = (b == FRAME_END) ? ESC_END : ESC_ESC;
  endfunction

endpackage

>>> src/sxfe_framer.sv
// Frame state and expansion of one payload byte into its list of line bytes.
module sxfe_framer (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  sxfe_pkg::byte_t     data_byte,
  input  logic                last_of_frame,
  output sxfe_pkg::line_list_t list
);

  sxfe_pkg::byte_t running_xor;
  sxfe_pkg::byte_t running_xor_next;
  logic            inside_frame;
  sxfe_pkg::byte_t csum;

  logic [sxfe_pkg::CNT_W-1:0] n_open;
  logic [sxfe_pkg::CNT_W-1:0] n_data;
  logic [sxfe_pkg::CNT_W-1:0] n_csum;

  assign running_xor_next = running_xor ^ data_byte;
  assign csum             = running_xor_next;

  // Positions: [open] data(1..2) [csum(1..2) close]
  assign n_open = inside_frame ? sxfe_pkg::CNT_W'(0) : sxfe_pkg::CNT_W'(1);
  assign n_data = n_open + sxfe_pkg::esc_len(data_byte);
  assign n_csum = n_data + sxfe_pkg::esc_len(csum);

  always_comb begin
    list.bytes = '0;
    if (!inside_frame) begin
      list.bytes[0] = sxfe_pkg::FRAME_END;
    end
    list.bytes[n_open] = sxfe_pkg::esc_first(data_byte);
    if (sxfe_pkg::esc_len(data_byte) == sxfe_pkg::CNT_W'(2)) begin
      list.bytes[n_open + sxfe_pkg::CNT_W'(1)] = sxfe_pkg::esc_second(data_byte);
    end
    if (last_of_frame) begin
      list.bytes[n_data] = sxfe_pkg::esc_first(csum);
      if (sxfe_pkg::esc_len(csum) == sxfe_pkg::CNT_W'(2)) begin
        list.bytes[n_data + sxfe_pkg::CNT_W'(1)] = sxfe_pkg::esc_second(csum);
      end
      list.bytes[n_csum] = sxfe_pkg::FRAME_END;
    end
    list.count = last_of_frame ? (n_csum + sxfe_pkg::CNT_W'(1)) : n_data;
    list.eof   = last_of_frame;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_xor  <= '0;
      inside_frame <= 1'b0;
    end else if (accept) begin
      if (last_of_frame) begin
        running_xor  <= '0;
        inside_frame <= 1'b0;
      end else begin
        running_xor  <= running_xor_next;
        inside_frame <= 1'b1;
      end
    end
  end

endmodule

>>> src/sxfe_serializer.sv
// Result register for an item's line bytes, one per cycle while out_ready.
module sxfe_serializer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  sxfe_pkg::line_list_t list_in,
  output sxfe_pkg::ser_status_t status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sxfe_pkg::byte_t      out_byte,
  output logic                 out_eof
);

  sxfe_pkg::line_list_t      list;
  logic [sxfe_pkg::CNT_W-1:0] idx;
  logic                      busy;
  logic                      last_pos;

  assign last_pos  = (idx == (list.count - sxfe_pkg::CNT_W'(1)));
  assign out_valid = busy;
  assign out_byte  = list.bytes[idx];
  assign out_eof   = list.eof && last_pos;

  assign status.can_load = !busy || (out_ready && last_pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && out_ready) begin
      if (last_pos) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + sxfe_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      list <= list_in;
    end
  end

endmodule

>>> src/slip_xor_frame_encoder.sv
// SLIP frame encoder with XOR checksum: payload bytes in, SLIP line bytes out.
// Each input item is expanded in one pass into its 1 to 6 line bytes (opening
// delimiter on the first byte of a frame, the byte escaped, and on the last
// byte the escaped XOR checksum and the closing delimiter with tlast). The
// list is held in a result register and sent one line byte per cycle while
// m_tready is high. An item has one line byte for a plain mid-frame byte, two
// for an escaped one, up to six for a one-byte frame with escaped data and
// checksum. The next item is taken in the cycle the previous list sends its
// final byte, so the output runs without gaps.
module slip_xor_frame_encoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // last_of_frame
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] line_byte
  output logic       m_tlast    // end_of_frame
);

  sxfe_pkg::line_list_t  list;
  sxfe_pkg::ser_status_t status;
  logic                  accept;

  assign s_tready = status.can_load;
  assign accept   = s_tvalid && s_tready;

  sxfe_framer u_framer (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (s_tdata),
    .last_of_frame (s_tlast),
    .list          (list)
  );

  sxfe_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .list_in   (list),
    .status    (status),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_eof   (m_tlast)
  );

endmodule

>>> src/sxfe_checker.sv
// Port-level checks of the encoder, bound to the top level.
`include "slip_xor_frame_encoder_macros.svh"

module sxfe_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // Frame close is always the delimiter.
  `SXFE_ASSERT_NOW(a_close_is_delim, m_tvalid && m_tlast, m_tdata == sxfe_pkg::FRAME_END)

  // Escape byte is followed at once by its second byte.
  `SXFE_ASSERT_NEXT(a_esc_pair, m_tvalid && m_tready && (m_tdata == sxfe_pkg::FRAME_ESC),
    m_tvalid && ((m_tdata == sxfe_pkg::ESC_END) || (m_tdata == sxfe_pkg::ESC_ESC)))

  // Input only stalls behind pending output.
  `SXFE_ASSERT_NOW(a_stall_has_cause, !s_tready, m_tvalid)

  // Stalled output holds.
  `SXFE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tlast))

endmodule

bind slip_xor_frame_encoder sxfe_checker u_sxfe_checker (.*);
